@@ hw/rtl/lamp_brightness_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Lamp brightness controller assertion macros
// Shorthand for clocked concurrent assertions with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef LAMP_BRIGHTNESS_CONTROLLER_MACROS_SVH
`define LAMP_BRIGHTNESS_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LBC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lamp controller assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lamp controller assertion failed");

`else

`define LBC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lamp brightness controller package
// Shared types, register codes and constants of the lamp controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned IDLE_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  // Band bounds reach base + 8 * step + gap, which needs eleven bits.
  localparam int unsigned BOUND_W    = 11;
  localparam int unsigned NUM_BANDS  = 8;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 4'd9;

  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd60000;
  localparam logic [7:0]  RST_BAND_BASE    = 8'd59;
  localparam logic [6:0]  RST_BAND_STEP    = 7'd22;
  localparam logic [5:0]  RST_BAND_GAP     = 6'd7;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_LIGHT  = 3'd1,
    KIND_MODE   = 3'd2,
    KIND_DIM    = 3'd3,
    KIND_BRIGHT = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_BAND_BASE    = 2'd1,
    REG_BAND_STEP    = 2'd2,
    REG_BAND_GAP     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] idle_timeout;
    logic [7:0]  band_base;
    logic [6:0]  band_step;
    logic [5:0]  band_gap;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [LEVEL_W-1:0] level;
  } band_res_t;

endpackage

@@ hw/rtl/lbc_item_if.sv @@
// ----------------------------------------------------------------------------
// Lamp controller input channel
// Valid/ready channel carrying one event beat: kind, light sample and sensors.
// ----------------------------------------------------------------------------
interface lbc_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] light_sample;
  logic       presence;
  logic       too_near;

  modport source (output valid, kind, light_sample, presence, too_near, input ready);
  modport sink   (input valid, kind, light_sample, presence, too_near, output ready);
endinterface

@@ hw/rtl/lbc_result_if.sv @@
// ----------------------------------------------------------------------------
// Lamp controller result channel
// Valid/ready channel carrying one status beat: lamp drive, level, mode, buzzer.
// ----------------------------------------------------------------------------
interface lbc_result_if;
  logic       valid;
  logic       ready;
  logic       lamp_on;
  logic [3:0] brightness;
  logic       auto_mode;
  logic       buzzer_on;

  modport source (output valid, lamp_on, brightness, auto_mode, buzzer_on, input ready);
  modport sink   (input valid, lamp_on, brightness, auto_mode, buzzer_on, output ready);
endinterface

@@ hw/rtl/lbc_band_sel.sv @@
// ----------------------------------------------------------------------------
// Lamp controller band selector
// Maps one light sample to a brightness level through the hysteresis bands.
// ----------------------------------------------------------------------------
module lbc_band_sel (
  input  lbc_pkg::cfg_t      cfg_i,
  input  logic [7:0]         sample_i,
  output lbc_pkg::band_res_t res_o
);

  logic [lbc_pkg::BOUND_W-1:0] s_ext;
  logic [lbc_pkg::BOUND_W-1:0] base_ext;
  logic [lbc_pkg::BOUND_W-1:0] step_ext;
  logic [lbc_pkg::BOUND_W-1:0] gap_ext;
  logic [lbc_pkg::BOUND_W-1:0] lo_b [lbc_pkg::NUM_BANDS+1];
  logic [lbc_pkg::BOUND_W-1:0] hi_b [lbc_pkg::NUM_BANDS+1];

  assign s_ext    = lbc_pkg::BOUND_W'(sample_i);
  assign base_ext = lbc_pkg::BOUND_W'(cfg_i.band_base);
  assign step_ext = lbc_pkg::BOUND_W'(cfg_i.band_step);
  assign gap_ext  = lbc_pkg::BOUND_W'(cfg_i.band_gap);

  // Entry j holds the lower and upper bound of band j; the upper bound of
  // the last entry plus the gap is where the dark band starts.
  always_comb begin
    for (int j = 0; j <= lbc_pkg::NUM_BANDS; j++) begin
      if (j == 0) begin
        lo_b[j] = base_ext;
        hi_b[j] = base_ext;
      end else begin
        lo_b[j] = base_ext + step_ext * lbc_pkg::BOUND_W'(j - 1) + gap_ext;
        hi_b[j] = base_ext + step_ext * lbc_pkg::BOUND_W'(j);
      end
    end
  end

  // Lowest matching band wins, and a sample below the base beats them all.
  always_comb begin
    res_o.hit   = 1'b0;
    res_o.level = '0;
    if (s_ext >= hi_b[lbc_pkg::NUM_BANDS] + gap_ext) begin
      res_o.hit   = 1'b1;
      res_o.level = '0;
    end
    for (int j = lbc_pkg::NUM_BANDS; j >= 1; j--) begin
      if (s_ext >= lo_b[j] && s_ext < hi_b[j]) begin
        res_o.hit   = 1'b1;
        res_o.level = lbc_pkg::MAX_LEVEL - lbc_pkg::LEVEL_W'(j);
      end
    end
    if (s_ext < base_ext) begin
      res_o.hit   = 1'b1;
      res_o.level = lbc_pkg::MAX_LEVEL;
    end
  end

endmodule

@@ hw/rtl/lamp_brightness_controller.sv @@
// ----------------------------------------------------------------------------
// Lamp brightness controller
// Ten-level PWM lamp with automatic light following, manual keys and an idle
// timeout.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive as beats on the item channel: a 1 ms tick, a light sample,
// a mode press, or a dim or brighten press, each with the presence and
// proximity sensor states. Every event beat yields exactly one status beat
// on the result channel with the lamp drive, level, mode and buzzer state.
// An event is registered on acceptance and processed once the result
// register is empty or being read; the new status is then written to the
// result register and offered. One event is taken per cycle unless stalled;
// the single processing stage with its state update sets that rate.
// If the receiver stalls, the finished result waits in its register while
// one further event waits in the input register; item ready then drops.
// Reset puts the lamp off at level 0 in automatic mode, clears the PWM phase
// and idle counter, and loads the default band and timeout registers. Users
// write registers via the configuration port only while idle (unenforced).
// ----------------------------------------------------------------------------
`include "lamp_brightness_controller_macros.svh"

module lamp_brightness_controller #(
  parameter int unsigned PWM_STEPS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lbc_item_if.sink                         item,
  lbc_result_if.source                     result,
  input  logic                             cfg_we_i,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned PhaseW = $clog2(PWM_STEPS);
  localparam logic [PhaseW:0] PhaseWrap = (PhaseW + 1)'(PWM_STEPS);

  lbc_pkg::cfg_t cfg_q;

  // Input register
  logic       in_valid_q;
  logic [2:0] in_kind_q;
  logic [7:0] in_sample_q;
  logic       in_presence_q;
  logic       in_too_near_q;

  // Controller state; it doubles as the result payload.
  logic                          mode_auto_q, mode_auto_d;
  logic [lbc_pkg::LEVEL_W-1:0]   level_q, level_d;
  logic [PhaseW-1:0]             phase_q, phase_d;
  logic [lbc_pkg::IDLE_W-1:0]    idle_q, idle_d;
  logic                          drive_q, drive_d;
  logic                          out_valid_q;
  logic                          buzzer_q;

  logic                          fire;
  logic [PhaseW:0]               phase_next;
  logic [8:0]                    gap_sum;
  logic [7:0]                    sample_gap;
  logic [lbc_pkg::IDLE_W-1:0]    timeout_ext;
  lbc_pkg::band_res_t            band_lo;
  lbc_pkg::band_res_t            band_hi;

  assign fire       = in_valid_q && (!out_valid_q || result.ready);
  assign item.ready = !in_valid_q || fire;

  assign result.valid      = out_valid_q;
  assign result.lamp_on    = drive_q;
  assign result.brightness = level_q;
  assign result.auto_mode  = mode_auto_q;
  assign result.buzzer_on  = buzzer_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout <= lbc_pkg::RST_IDLE_TIMEOUT;
      cfg_q.band_base    <= lbc_pkg::RST_BAND_BASE;
      cfg_q.band_step    <= lbc_pkg::RST_BAND_STEP;
      cfg_q.band_gap     <= lbc_pkg::RST_BAND_GAP;
    end else if (cfg_we_i) begin
      case (lbc_pkg::cfg_idx_e'(cfg_idx_i))
        lbc_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data_i;
        lbc_pkg::REG_BAND_BASE:    cfg_q.band_base    <= cfg_data_i[7:0];
        lbc_pkg::REG_BAND_STEP:    cfg_q.band_step    <= cfg_data_i[6:0];
        lbc_pkg::REG_BAND_GAP:     cfg_q.band_gap     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // The second band check uses the sample plus the gap, saturated at 255.
  assign gap_sum     = 9'(in_sample_q) + 9'(cfg_q.band_gap);
  assign sample_gap  = gap_sum[8] ? 8'hFF : gap_sum[7:0];
  assign timeout_ext = lbc_pkg::IDLE_W'(cfg_q.idle_timeout);

  lbc_band_sel u_band_lo (
    .cfg_i    (cfg_q),
    .sample_i (in_sample_q),
    .res_o    (band_lo)
  );

  lbc_band_sel u_band_hi (
    .cfg_i    (cfg_q),
    .sample_i (sample_gap),
    .res_o    (band_hi)
  );

  assign phase_next = (PhaseW + 1)'(phase_q) + (PhaseW + 1)'(1);

  always_comb begin
    mode_auto_d = mode_auto_q;
    level_d     = level_q;
    phase_d     = phase_q;
    idle_d      = idle_q;
    drive_d     = drive_q;
    case (lbc_pkg::kind_e'(in_kind_q))
      lbc_pkg::KIND_TICK: begin
        if (mode_auto_q && idle_q != '1) begin
          idle_d = idle_q + lbc_pkg::IDLE_W'(1);
        end
        if (phase_next >= PhaseWrap) begin
          phase_d = '0;
          if (level_q != '0) begin
            drive_d = 1'b1;
          end
        end else begin
          phase_d = phase_next[PhaseW-1:0];
        end
        if (lbc_pkg::LEVEL_W'(phase_d) == level_q && level_q != lbc_pkg::MAX_LEVEL) begin
          drive_d = 1'b0;
        end
      end
      lbc_pkg::KIND_LIGHT: begin
        // The gap-shifted check overrides the plain one when it matches.
        if (mode_auto_q && idle_q < timeout_ext) begin
          if (band_hi.hit) begin
            level_d = band_hi.level;
          end else if (band_lo.hit) begin
            level_d = band_lo.level;
          end
        end
      end
      lbc_pkg::KIND_MODE: begin
        mode_auto_d = !mode_auto_q;
      end
      lbc_pkg::KIND_DIM: begin
        if (!mode_auto_q && level_q != '0) begin
          level_d = level_q - lbc_pkg::LEVEL_W'(1);
        end
      end
      lbc_pkg::KIND_BRIGHT: begin
        if (!mode_auto_q && level_q < lbc_pkg::MAX_LEVEL) begin
          level_d = level_q + lbc_pkg::LEVEL_W'(1);
        end
      end
      default: ;
    endcase
    if (in_presence_q) begin
      idle_d = '0;
    end
    if (idle_d > timeout_ext) begin
      idle_d  = timeout_ext;
      level_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item.ready) begin
      in_valid_q <= item.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item.valid && item.ready) begin
      in_kind_q     <= item.kind;
      in_sample_q   <= item.light_sample;
      in_presence_q <= item.presence;
      in_too_near_q <= item.too_near;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_auto_q <= 1'b1;
      level_q     <= '0;
      phase_q     <= '0;
      idle_q      <= '0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_auto_q <= mode_auto_d;
        level_q     <= level_d;
        phase_q     <= phase_d;
        idle_q      <= idle_d;
        drive_q     <= drive_d;
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      buzzer_q <= in_too_near_q;
    end
  end

  `LBC_ASSERT_SAME(a_level_range, clk_i, rst_ni, 1'b1, level_q <= lbc_pkg::MAX_LEVEL)
  `LBC_ASSERT_SAME(a_phase_range, clk_i, rst_ni, 1'b1, (PhaseW + 1)'(phase_q) < PhaseWrap)
  `LBC_ASSERT_NEXT(a_idle_bound, clk_i, rst_ni, fire,
                   idle_q <= lbc_pkg::IDLE_W'($past(cfg_q.idle_timeout)))
  `LBC_ASSERT_NEXT(a_item_held, clk_i, rst_ni, in_valid_q && !fire, in_valid_q)
  `LBC_ASSERT_NEXT(a_manual_step, clk_i, rst_ni, fire && !mode_auto_q,
                   level_q == $past(level_q) || level_q == $past(level_q) + 4'd1 ||
                   level_q == $past(level_q) - 4'd1 || level_q == 4'd0)

endmodule
